// ----- design/spq_pkg.sv -----
package spq_pkg;

	localparam int CAPACITY = 8;
	localparam int KEY_W    = 32;
	localparam int OCC_W    = 4;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        count_t;

	localparam logic KIND_INSERT  = 1'b0;
	localparam logic KIND_DEQUEUE = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic kind;
		key_t key;
	} req_t;

	typedef struct packed {
		key_t             out_key;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} rsp_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic deq;
		key_t key;
	} spq_ctrl_t;

	// What a cell shows its neighbors
	typedef struct packed {
		key_t key;
		logic valid;
		logic less;
	} spq_nbr_t;

endpackage

// ----- design/spq_cell.sv -----
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_ctrl_t ctrl,
	input  spq_pkg::spq_nbr_t  left,
	input  spq_pkg::spq_nbr_t  right,
	output spq_pkg::spq_nbr_t  self
);

	spq_pkg::key_t key_q;
	logic          valid_q;
	logic          less;

	// Held key is strictly below the incoming key: it and all cells after it move right
	assign less = valid_q && (key_q < ctrl.key);

	assign self.key   = key_q;
	assign self.valid = valid_q;
	assign self.less  = less;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= left.valid;
		end else if (ctrl.deq) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left.less) begin
				key_q <= left.key;
			end else if (!valid_q || less) begin
				key_q <= ctrl.key;
			end
		end else if (ctrl.deq) begin
			key_q <= right.key;
		end
	end

endmodule

// ----- design/sorted_max_priority_queue_core.sv -----
// Sorted max-priority queue built as a row of shift-register cells.
//
// Request channel: present req (kind, key) with start high; a request is
// taken at every rising edge where start is high and busy is low. busy is
// held low, so a new request may be issued in every cycle.
// kind selects insert or dequeue of the largest key. Equal keys leave in
// arrival order.
//
// Result channel: one result per request, shown on rsp for exactly one
// cycle with done high; rsp and done are registered at the request edge. The receiver
// cannot stall; capture rsp whenever done is high.
//
// Throughput is one request per cycle. Every cell compares its key with the
// incoming key at once and either holds, takes the new key, or takes its
// neighbor's key, so the whole row updates at the request edge.
//
// Reset clears every cell's valid bit and the count; key storage is not
// cleared and is only read through valid cells.
module sorted_max_priority_queue_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  spq_pkg::req_t req,
	output logic          done,
	output spq_pkg::rsp_t rsp
);

	spq_pkg::spq_ctrl_t ctrl;
	spq_pkg::spq_nbr_t  cell_out [spq_pkg::CAPACITY];
	spq_pkg::spq_nbr_t  edge_left;
	spq_pkg::spq_nbr_t  edge_right;

	spq_pkg::count_t count_q;
	spq_pkg::count_t count_next;
	spq_pkg::rsp_t   rsp_q;
	spq_pkg::rsp_t   rsp_next;
	logic            done_q;

	logic accept;
	logic full;
	logic empty;
	logic is_ins;
	logic is_deq;

	// The row keeps up with every request
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid cells are packed at the head of the row
	assign full  = cell_out[spq_pkg::CAPACITY-1].valid;
	assign empty = !cell_out[0].valid;

	assign is_ins = accept && (req.kind == spq_pkg::KIND_INSERT);
	assign is_deq = accept && (req.kind == spq_pkg::KIND_DEQUEUE);

	// Drop inserts into a full row and dequeues from an empty one
	assign ctrl.ins = is_ins && !full;
	assign ctrl.deq = is_deq && !empty;
	assign ctrl.key = req.key;

	// Head cell sees a valid, never-shifting neighbor on its left; the tail
	// pulls an empty slot in from the right on dequeue
	assign edge_left.key    = '0;
	assign edge_left.valid  = 1'b1;
	assign edge_left.less   = 1'b0;
	assign edge_right.key   = '0;
	assign edge_right.valid = 1'b0;
	assign edge_right.less  = 1'b0;

	for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
		spq_pkg::spq_nbr_t left_in;
		spq_pkg::spq_nbr_t right_in;

		if (i == 0) begin : g_head
			assign left_in = edge_left;
		end else begin : g_body_l
			assign left_in = cell_out[i-1];
		end

		if (i == spq_pkg::CAPACITY - 1) begin : g_tail
			assign right_in = edge_right;
		end else begin : g_body_r
			assign right_in = cell_out[i+1];
		end

		spq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.left   (left_in),
			.right  (right_in),
			.self   (cell_out[i])
		);
	end

	// Build the result from the row as it stood before this request
	always_comb begin
		count_next = count_q;
		if (ctrl.ins) begin
			count_next = count_q + spq_pkg::CNT_W'(1);
		end else if (ctrl.deq) begin
			count_next = count_q - spq_pkg::CNT_W'(1);
		end

		rsp_next.out_key   = ctrl.deq ? cell_out[0].key : '0;
		rsp_next.status    = spq_pkg::STATUS_OK;
		rsp_next.occupancy = spq_pkg::OCC_W'(count_next);
		if (is_ins && full) begin
			rsp_next.status = spq_pkg::STATUS_FULL;
		end else if (is_deq && empty) begin
			rsp_next.status = spq_pkg::STATUS_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_next;
			done_q  <= accept;
		end
	end

	// Result payload needs no reset; done qualifies it
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- test/tb.sv -----
module tb;

	// Block ports
	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	spq_pkg::req_t  req;
	logic           done;
	spq_pkg::rsp_t  rsp;

	// Shadow copy of the queue: keys in descending order, equal keys in arrival order
	spq_pkg::key_t  model_keys [spq_pkg::CAPACITY];
	int             model_count;

	// Results still owed by the block, oldest first
	spq_pkg::rsp_t  pending_results [$];
	spq_pkg::rsp_t  oldest_result;

	int             error_count = 0;
	int             requests_sent;
	int             results_checked = 0;
	int             full_drops = 0;
	int             empty_pops = 0;
	int             idle_pct;

	sorted_max_priority_queue_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop in case the block never answers
	initial begin
		#200000;
		$display("watchdog expired with %0d results outstanding", pending_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	// Apply one request to the shadow queue and return the result it must produce.
	function automatic spq_pkg::rsp_t apply_queue_op(spq_pkg::req_t r);
		spq_pkg::rsp_t res;
		int            pos;
		res = '0;
		res.status = spq_pkg::STATUS_OK;
		if (r.kind == spq_pkg::KIND_INSERT) begin
			if (model_count >= spq_pkg::CAPACITY) begin
				// Full: drop the key, leave the queue alone
				res.status = spq_pkg::STATUS_FULL;
			end else begin
				// Land after every held key that is greater or equal
				pos = model_count;
				for (int i = 0; i < model_count; i++) begin
					if (model_keys[i] < r.key) begin
						pos = i;
						break;
					end
				end
				for (int i = model_count; i > pos; i--)
					model_keys[i] = model_keys[i-1];
				model_keys[pos] = r.key;
				model_count++;
			end
		end else begin
			if (model_count == 0) begin
				res.status = spq_pkg::STATUS_EMPTY;
			end else begin
				// Pop the head, advance the rest by one
				res.out_key = model_keys[0];
				for (int i = 1; i < model_count; i++)
					model_keys[i-1] = model_keys[i];
				model_count--;
			end
		end
		res.occupancy = spq_pkg::OCC_W'(model_count);
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= 50)
			$display("MISMATCH t=%0t result %0d: %s got %h want %h",
				$realtime, results_checked, what, got, want);
	endtask

	// Predict on every accepted request, then check every strobed result.
	// Prediction goes first so a result can never overtake its own request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				pending_results.push_back(apply_queue_op(req));
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", rsp.out_key, '0);
				end else begin
					oldest_result = pending_results.pop_front();
					if (rsp.out_key !== oldest_result.out_key)
						report_mismatch("out_key", rsp.out_key, oldest_result.out_key);
					if (rsp.status !== oldest_result.status)
						report_mismatch("status", 32'(rsp.status),
							32'(oldest_result.status));
					if (rsp.occupancy !== oldest_result.occupancy)
						report_mismatch("occupancy", 32'(rsp.occupancy),
							32'(oldest_result.occupancy));
					if (oldest_result.status == spq_pkg::STATUS_FULL)
						full_drops++;
					if (oldest_result.status == spq_pkg::STATUS_EMPTY)
						empty_pops++;
					results_checked++;
				end
			end
		end
	end

	// Issue one request. Entered and left on a falling edge; start stays high on
	// return so back-to-back requests need no extra assignment in the same step.
	task automatic send_request(logic kind, spq_pkg::key_t key);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= '{kind: kind, key: key};
		do
			@(posedge clk);
		while (busy);
		requests_sent++;
		@(negedge clk);
	endtask

	// Hold start low until every owed result has come back or the guard runs out.
	task automatic wait_for_results();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (pending_results.size() != 0 && guard < 1000) begin
			@(negedge clk);
			guard++;
		end
		repeat (3) @(negedge clk);
	endtask

	// Mix of full-range keys, extremes, and a narrow band that forces ties.
	function automatic spq_pkg::key_t pick_key();
		spq_pkg::key_t k;
		case ($urandom_range(9))
			0:       k = 32'sh7fffffff;
			1:       k = 32'sh80000000;
			2, 3:    k = $signed($urandom_range(6)) - 3;
			default: k = $urandom;
		endcase
		return k;
	endfunction

	task automatic test_directed();
		idle_pct = 0;
		// Dequeue on empty, with a nonzero key that must be ignored
		send_request(spq_pkg::KIND_DEQUEUE, 32'sh7fffffff);
		// Fill with extremes, zero, minus one and ties
		send_request(spq_pkg::KIND_INSERT, 32'sh7fffffff);
		send_request(spq_pkg::KIND_INSERT, 32'sh80000000);
		send_request(spq_pkg::KIND_INSERT, 0);
		send_request(spq_pkg::KIND_INSERT, -1);
		send_request(spq_pkg::KIND_INSERT, 1);
		send_request(spq_pkg::KIND_INSERT, 5);
		send_request(spq_pkg::KIND_INSERT, 5);
		send_request(spq_pkg::KIND_INSERT, 32'sh7fffffff);
		// Insert when full, at both ends of the key range
		send_request(spq_pkg::KIND_INSERT, 32'sh7fffffff);
		send_request(spq_pkg::KIND_INSERT, 32'sh80000000);
		// Drain completely, then dequeue on empty once more
		repeat (spq_pkg::CAPACITY) send_request(spq_pkg::KIND_DEQUEUE, $urandom);
		send_request(spq_pkg::KIND_DEQUEUE, 32'sh80000000);
		wait_for_results();
	endtask

	// Random traffic; insert bias drifts so the queue swings between empty and full.
	task automatic test_random(int count, int gap_pct);
		int   insert_pct;
		logic kind;
		idle_pct   = gap_pct;
		insert_pct = 50;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0)
				insert_pct = 25 * $urandom_range(1, 3);
			kind = ($urandom_range(99) < insert_pct) ? spq_pkg::KIND_INSERT
				: spq_pkg::KIND_DEQUEUE;
			send_request(kind, kind == spq_pkg::KIND_INSERT ? pick_key()
				: spq_pkg::key_t'($urandom));
		end
		wait_for_results();
	endtask

	// Back-to-back overfill then overdrain, hammering both boundaries.
	task automatic test_fill_drain(int rounds);
		idle_pct = 0;
		repeat (rounds) begin
			repeat (spq_pkg::CAPACITY + 2) send_request(spq_pkg::KIND_INSERT, pick_key());
			repeat (spq_pkg::CAPACITY + 2) send_request(spq_pkg::KIND_DEQUEUE, $urandom);
		end
		wait_for_results();
	endtask

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		req             = '0;
		model_count     = 0;
		requests_sent   = 0;
		idle_pct        = 0;
		for (int i = 0; i < spq_pkg::CAPACITY; i++)
			model_keys[i] = '0;

		// Hold reset, then release it on a falling edge
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random(400, 0);
		test_random(400, 65);
		test_random(400, 24);
		test_fill_drain(20);

		if (pending_results.size() != 0)
			report_mismatch("results never arrived", 32'(pending_results.size()), '0);

		$display("Covered %0d requests and %0d checked results across idle levels 0/65/24 pct",
			requests_sent, results_checked);
		$display("Saw %0d dropped inserts on full and %0d dequeues on empty",
			full_drops, empty_pops);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_max_priority_queue_core.sv
test/tb.sv
